// ===== design/bptc_pkg.sv =====
// Shared types and constants for the barometric compensation pipeline.
// No dependencies.
package bptc_pkg;

    localparam int unsigned DIV_W = 64;

    // configuration register indexes
    localparam logic [7:0] REG_TEMP_COEF   = 8'd0;
    localparam logic [7:0] REG_PRESS_LOW   = 8'd1;
    localparam logic [7:0] REG_PRESS_HIGH  = 8'd2;
    localparam logic [7:0] REG_PRESS_NINE  = 8'd3;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } bptc_in_t;

    typedef struct packed {
        logic signed [23:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } bptc_out_t;

    // temperature results riding alongside the pressure path
    typedef struct packed {
        logic [23:0] tc;
        logic [31:0] fine;
    } bptc_side_t;

endpackage

// ===== design/bptc_mul64.sv =====
// 64x64 wrapping multiplier (low 64 bits), two register stages.
// Uses 32x32 partial products; no package dependency.
module bptc_mul64 (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        ll_reg <= 64'(a[31:0]) * 64'(b[31:0]);
        lh_reg <= a[31:0] * b[63:32];
        hl_reg <= a[63:32] * b[31:0];
        p_reg  <= ll_reg + {lh_reg + hl_reg, 32'd0};
    end

    assign p = p_reg;
endmodule

// ===== design/bptc_div64.sv =====
// Pipelined 64-bit signed divider, truncating toward zero, one quotient bit per stage.
// Depends on bptc_pkg (DIV_W, bptc_side_t).
module bptc_div64 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  logic [63:0]          num,
    input  logic [63:0]          den,
    input  bptc_pkg::bptc_side_t side_in,
    output logic                 out_vld,
    output logic [63:0]          quo,
    output logic                 den_zero,
    output bptc_pkg::bptc_side_t side_out
);
    import bptc_pkg::*;

    logic [63:0] r_reg    [0:DIV_W];
    logic [63:0] dq_reg   [0:DIV_W];
    logic [63:0] d_reg    [0:DIV_W];
    logic        neg_reg  [0:DIV_W];
    logic        zero_reg [0:DIV_W];
    logic        vld_reg  [0:DIV_W];
    bptc_side_t  side_reg [0:DIV_W];

    logic        out_vld_reg;
    logic [63:0] quo_reg;
    logic        zero_out_reg;
    bptc_side_t  side_out_reg;

    // operand prep: magnitudes and result sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]    <= 64'd0;
        dq_reg[0]   <= num[63] ? 64'd0 - num : num;
        d_reg[0]    <= den[63] ? 64'd0 - den : den;
        neg_reg[0]  <= num[63] ^ den[63];
        zero_reg[0] <= (den == 64'd0);
        side_reg[0] <= side_in;
    end

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_step
        logic [63:0] t;
        logic        ge;

        assign t  = {r_reg[i][62:0], dq_reg[i][63]};
        assign ge = (t >= d_reg[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[i+1]    <= ge ? t - d_reg[i] : t;
            dq_reg[i+1]   <= {dq_reg[i][62:0], ge};
            d_reg[i+1]    <= d_reg[i];
            neg_reg[i+1]  <= neg_reg[i];
            zero_reg[i+1] <= zero_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    // sign fixup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= neg_reg[DIV_W] ? 64'd0 - dq_reg[DIV_W] : dq_reg[DIV_W];
        zero_out_reg <= zero_reg[DIV_W];
        side_out_reg <= side_reg[DIV_W];
    end

    assign out_vld  = out_vld_reg;
    assign quo      = quo_reg;
    assign den_zero = zero_out_reg;
    assign side_out = side_out_reg;
endmodule

// ===== design/baro_temp_pressure_compensation_unit.sv =====
// Barometric temperature/pressure compensation, 64-bit integer scheme, top level.
// Depends on bptc_pkg, bptc_mul64, bptc_div64.
//
// A sample beat is taken on every clock where start is high; busy is always
// low, so a new raw temperature/pressure pair may enter every cycle. Each beat
// produces exactly one result beat, shown for one cycle with result_valid high;
// the result side cannot stall, so the pipeline never holds. The pipeline is
// built from the 64-stage radix-2 restoring divider (plus operand prep and
// sign fixup), the seven temperature stages, five levels of 64-bit multipliers
// (three ahead of the divider, two after) and five add/shift stages.
// Calibration words are written through cfg_valid/cfg_index/cfg_data
// (cfg_ready is always high); indexes beyond the list are ignored. Writes
// must only happen with no sample in flight.
module baro_temp_pressure_compensation_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bptc_pkg::bptc_in_t  sample,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output logic                result_valid,
    output bptc_pkg::bptc_out_t result
);
    import bptc_pkg::*;

    // ---------------- calibration registers ----------------
    logic [47:0] tcoef_reg;
    logic [63:0] plow_reg;
    logic [63:0] phigh_reg;
    logic [15:0] p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcoef_reg <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            p9_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEMP_COEF:  tcoef_reg <= cfg_data[47:0];
                REG_PRESS_LOW:  plow_reg  <= cfg_data;
                REG_PRESS_HIGH: phigh_reg <= cfg_data;
                REG_PRESS_NINE: p9_reg    <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // coefficient unpack
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, tcoef_reg[15:0]};
    assign t2 = {{16{tcoef_reg[31]}}, tcoef_reg[31:16]};
    assign t3 = {{16{tcoef_reg[47]}}, tcoef_reg[47:32]};
    assign p1 = {48'd0, plow_reg[15:0]};
    assign p2 = {{48{plow_reg[31]}}, plow_reg[31:16]};
    assign p3 = {{48{plow_reg[47]}}, plow_reg[47:32]};
    assign p4 = {{48{plow_reg[63]}}, plow_reg[63:48]};
    assign p5 = {{48{phigh_reg[15]}}, phigh_reg[15:0]};
    assign p6 = {{48{phigh_reg[31]}}, phigh_reg[31:16]};
    assign p7 = {{48{phigh_reg[47]}}, phigh_reg[47:32]};
    assign p8 = {{48{phigh_reg[63]}}, phigh_reg[63:48]};
    assign p9 = {{48{p9_reg[15]}}, p9_reg};

    // ---------------- valid chain outside the divider ----------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic s7_vld_reg, a1_vld_reg, a2_vld_reg, b1_vld_reg, b2_vld_reg;
    logic c_vld_reg, c2_vld_reg, d1_vld_reg, d2_vld_reg, e_vld_reg;
    logic f1_vld_reg, f2_vld_reg, g1_vld_reg, g2_vld_reg, h_vld_reg, out_vld_reg;
    logic div_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            a1_vld_reg  <= 1'b0;
            a2_vld_reg  <= 1'b0;
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            c_vld_reg   <= 1'b0;
            c2_vld_reg  <= 1'b0;
            d1_vld_reg  <= 1'b0;
            d2_vld_reg  <= 1'b0;
            e_vld_reg   <= 1'b0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            g1_vld_reg  <= 1'b0;
            g2_vld_reg  <= 1'b0;
            h_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= start & ~busy;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            a1_vld_reg  <= s7_vld_reg;
            a2_vld_reg  <= a1_vld_reg;
            b1_vld_reg  <= a2_vld_reg;
            b2_vld_reg  <= b1_vld_reg;
            c_vld_reg   <= b2_vld_reg;
            c2_vld_reg  <= c_vld_reg;
            d1_vld_reg  <= c2_vld_reg;
            d2_vld_reg  <= d1_vld_reg;
            e_vld_reg   <= d2_vld_reg;
            f1_vld_reg  <= div_vld;
            f2_vld_reg  <= f1_vld_reg;
            g1_vld_reg  <= f2_vld_reg;
            g2_vld_reg  <= g1_vld_reg;
            h_vld_reg   <= g2_vld_reg;
            out_vld_reg <= h_vld_reg;
        end
    end

    // ---------------- temperature, 32-bit wrapping ----------------
    logic [19:0] s1_adt_reg, s1_adp_reg;
    logic [31:0] s2_a_reg, s2_d_reg;
    logic [19:0] s2_adp_reg, s3_adp_reg, s4_adp_reg, s5_adp_reg, s6_adp_reg, s7_adp_reg;
    logic [31:0] s3_ma_reg, s3_dd_reg;
    logic [31:0] s4_v1_reg, s4_q_reg;
    logic [31:0] s5_v1_reg, s5_qt_reg;
    logic [31:0] s6_fine_reg;
    logic [31:0] f5, tcw;
    logic [23:0] tc_sat;
    bptc_side_t  s7_side_reg;
    logic [63:0] s7_w1_reg;

    assign f5  = (s6_fine_reg << 2) + s6_fine_reg + 32'd128;
    assign tcw = 32'($signed(f5) >>> 8);

    // (fine*5+128)>>8 on 32 bits always fits in 24 bits, clamp kept for safety
    always_comb
    begin
        if ($signed(tcw) > $signed(32'sd8388607))
            tc_sat = 24'h7FFFFF;
        else if ($signed(tcw) < $signed(-32'sd8388608))
            tc_sat = 24'h800000;
        else
            tc_sat = tcw[23:0];
    end

    always_ff @(posedge clk)
    begin
        s1_adt_reg  <= sample.raw_temperature;
        s1_adp_reg  <= sample.raw_pressure;
        s2_a_reg    <= {15'd0, s1_adt_reg[19:3]} - (t1 << 1);
        s2_d_reg    <= {16'd0, s1_adt_reg[19:4]} - t1;
        s2_adp_reg  <= s1_adp_reg;
        s3_ma_reg   <= s2_a_reg * t2;
        s3_dd_reg   <= s2_d_reg * s2_d_reg;
        s3_adp_reg  <= s2_adp_reg;
        s4_v1_reg   <= 32'($signed(s3_ma_reg) >>> 11);
        s4_q_reg    <= 32'($signed(s3_dd_reg) >>> 12);
        s4_adp_reg  <= s3_adp_reg;
        s5_v1_reg   <= s4_v1_reg;
        s5_qt_reg   <= s4_q_reg * t3;
        s5_adp_reg  <= s4_adp_reg;
        s6_fine_reg <= s5_v1_reg + 32'($signed(s5_qt_reg) >>> 14);
        s6_adp_reg  <= s5_adp_reg;
        s7_side_reg <= '{tc: tc_sat, fine: s6_fine_reg};
        s7_w1_reg   <= {{32{s6_fine_reg[31]}}, s6_fine_reg} - 64'd128000;
        s7_adp_reg  <= s6_adp_reg;
    end

    // ---------------- pressure, 64-bit wrapping ----------------
    // group A: w1*w1, w1*P5, w1*P2
    logic [63:0] ma_sq, ma_p5, ma_p2;
    bptc_mul64 u_mul_sq (.clk(clk), .a(s7_w1_reg), .b(s7_w1_reg), .p(ma_sq));
    bptc_mul64 u_mul_p5 (.clk(clk), .a(s7_w1_reg), .b(p5), .p(ma_p5));
    bptc_mul64 u_mul_p2 (.clk(clk), .a(s7_w1_reg), .b(p2), .p(ma_p2));

    bptc_side_t  a1_side_reg, a2_side_reg;
    logic [19:0] a1_adp_reg, a2_adp_reg;

    // group B: sq*P6, sq*P3
    logic [63:0] mb_p6, mb_p3;
    bptc_mul64 u_mul_p6 (.clk(clk), .a(ma_sq), .b(p6), .p(mb_p6));
    bptc_mul64 u_mul_p3 (.clk(clk), .a(ma_sq), .b(p3), .p(mb_p3));

    bptc_side_t  b1_side_reg, b2_side_reg;
    logic [19:0] b1_adp_reg, b2_adp_reg;
    logic [63:0] b1_p5_reg, b2_p5_reg, b1_p2_reg, b2_p2_reg;

    bptc_side_t  c_side_reg, c2_side_reg;
    logic [19:0] c_adp_reg;
    logic [63:0] c_w2_reg, c_w1_reg;
    logic [63:0] c2_x_reg, c2_diff_reg;

    always_ff @(posedge clk)
    begin
        a1_side_reg <= s7_side_reg;
        a2_side_reg <= a1_side_reg;
        a1_adp_reg  <= s7_adp_reg;
        a2_adp_reg  <= a1_adp_reg;
        b1_side_reg <= a2_side_reg;
        b2_side_reg <= b1_side_reg;
        b1_adp_reg  <= a2_adp_reg;
        b2_adp_reg  <= b1_adp_reg;
        b1_p5_reg   <= ma_p5;
        b2_p5_reg   <= b1_p5_reg;
        b1_p2_reg   <= ma_p2;
        b2_p2_reg   <= b1_p2_reg;
        c_side_reg  <= b2_side_reg;
        c_adp_reg   <= b2_adp_reg;
        c_w2_reg    <= mb_p6 + (b2_p5_reg << 17) + (p4 << 35);
        c_w1_reg    <= 64'($signed(mb_p3) >>> 8) + (b2_p2_reg << 12);
        c2_side_reg <= c_side_reg;
        c2_x_reg    <= (64'd1 << 47) + c_w1_reg;
        c2_diff_reg <= ((64'd1048576 - {44'd0, c_adp_reg}) << 31) - c_w2_reg;
    end

    // group D: (2^47+w1)*P1, numerator*3125
    logic [63:0] md_p1, md_num;
    bptc_mul64 u_mul_p1  (.clk(clk), .a(c2_x_reg), .b(p1), .p(md_p1));
    bptc_mul64 u_mul_num (.clk(clk), .a(c2_diff_reg), .b(64'd3125), .p(md_num));

    bptc_side_t  d1_side_reg, d2_side_reg, e_side_reg;
    logic [63:0] e_den_reg, e_num_reg;

    always_ff @(posedge clk)
    begin
        d1_side_reg <= c2_side_reg;
        d2_side_reg <= d1_side_reg;
        e_side_reg  <= d2_side_reg;
        e_den_reg   <= 64'($signed(md_p1) >>> 33);
        e_num_reg   <= md_num;
    end

    // division; a zero divisor flags the result invalid further down
    logic [63:0] div_q;
    logic        div_zero;
    bptc_side_t  div_side;

    bptc_div64 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (e_vld_reg),
        .num      (e_num_reg),
        .den      (e_den_reg),
        .side_in  (e_side_reg),
        .out_vld  (div_vld),
        .quo      (div_q),
        .den_zero (div_zero),
        .side_out (div_side)
    );

    // group F: s*s with s = p>>13, P8*p
    logic [63:0] div_s;
    logic [63:0] mf_ss, mf_p8;
    assign div_s = 64'($signed(div_q) >>> 13);

    bptc_mul64 u_mul_ss (.clk(clk), .a(div_s), .b(div_s), .p(mf_ss));
    bptc_mul64 u_mul_p8 (.clk(clk), .a(p8), .b(div_q), .p(mf_p8));

    // group G: P9*s*s
    logic [63:0] mg_p9;
    bptc_mul64 u_mul_p9 (.clk(clk), .a(p9), .b(mf_ss), .p(mg_p9));

    bptc_side_t  f1_side_reg, f2_side_reg, g1_side_reg, g2_side_reg, h_side_reg;
    logic        f1_zero_reg, f2_zero_reg, g1_zero_reg, g2_zero_reg, h_zero_reg;
    logic [63:0] f1_p_reg, f2_p_reg, g1_p_reg, g2_p_reg;
    logic [63:0] g1_p8_reg, g2_p8_reg;
    logic [63:0] h_sum_reg;
    logic [63:0] pr;
    logic [31:0] press_sat;
    bptc_out_t   out_reg;

    always_ff @(posedge clk)
    begin
        f1_side_reg <= div_side;
        f2_side_reg <= f1_side_reg;
        g1_side_reg <= f2_side_reg;
        g2_side_reg <= g1_side_reg;
        h_side_reg  <= g2_side_reg;
        f1_zero_reg <= div_zero;
        f2_zero_reg <= f1_zero_reg;
        g1_zero_reg <= f2_zero_reg;
        g2_zero_reg <= g1_zero_reg;
        h_zero_reg  <= g2_zero_reg;
        f1_p_reg    <= div_q;
        f2_p_reg    <= f1_p_reg;
        g1_p_reg    <= f2_p_reg;
        g2_p_reg    <= g1_p_reg;
        g1_p8_reg   <= mf_p8;
        g2_p8_reg   <= g1_p8_reg;
        h_sum_reg   <= g2_p_reg + 64'($signed(mg_p9) >>> 25)
                       + 64'($signed(g2_p8_reg) >>> 19);
    end

    // final scale, offset and clamp to 0..2^32-1
    assign pr = 64'($signed(h_sum_reg) >>> 8) + (p7 << 4);

    always_comb
    begin
        if (h_zero_reg || pr[63])
            press_sat = 32'd0;
        else if (pr[62:32] != 31'd0)
            press_sat = 32'hFFFF_FFFF;
        else
            press_sat = pr[31:0];
    end

    always_ff @(posedge clk)
    begin
        out_reg.temperature_centi <= h_side_reg.tc;
        out_reg.fine_temperature  <= h_side_reg.fine;
        out_reg.pressure_q24_8    <= press_sat;
        out_reg.pressure_invalid  <= h_zero_reg;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;
endmodule
